FILE: hdl/ssr_pkg.sv
// shared constants, types and digit helpers for the seven-segment refresh block
package ssr_pkg;

    localparam int CHAIN_BYTES    = 5;
    localparam int NUM_INDICATORS = 30;
    localparam int FRAME_BITS     = CHAIN_BYTES * 8;
    localparam int CNT_W          = $clog2(FRAME_BITS);

    localparam int MODE_W  = 2;
    localparam int ID_W    = 7;
    localparam int VALUE_W = 8;
    localparam int ON_W    = 30;
    localparam int DIGIT_W = 4;

    localparam logic [7:0]      SEL_KEEP_MASK = 8'hFC;
    localparam logic [7:0]      SEL_IDLE      = 8'h00;
    localparam logic [7:0]      SEL_TENS      = 8'h02;
    localparam logic [7:0]      SEL_UNITS     = 8'h01;
    localparam logic [ID_W-1:0] DISPLAY_MAX   = 7'd99;
    localparam logic [CNT_W-1:0] LAST_BIT     = CNT_W'(FRAME_BITS - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE    = 2'd0,
        MODE_CHOOSE  = 2'd1,
        MODE_CONTROL = 2'd2,
        MODE_OTHER   = 2'd3
    } mode_t;

    // byte 0 is sent first: it sits in the top bits
    typedef logic [FRAME_BITS-1:0] frame_t;

    // active-low segment patterns
    function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h03;
            4'd1:    p = 8'h9F;
            4'd2:    p = 8'h25;
            4'd3:    p = 8'h0D;
            4'd4:    p = 8'h99;
            4'd5:    p = 8'h49;
            4'd6:    p = 8'h41;
            4'd7:    p = 8'h1F;
            4'd8:    p = 8'h01;
            4'd9:    p = 8'h09;
            default: p = 8'hFF;
        endcase
        return p;
    endfunction

    // v / 10 for v <= 99 by reciprocal multiply
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [ID_W-1:0] v);
        logic [13:0] prod;
        prod = 14'(v) * 14'd103;
        return prod[13:10];
    endfunction

    // v % 10 given the tens digit
    function automatic logic [DIGIT_W-1:0] units_of(input logic [ID_W-1:0] v,
                                                    input logic [DIGIT_W-1:0] t);
        logic [ID_W-1:0] r;
        r = v - {t, 3'b000} - {2'b00, t, 1'b0};
        return r[DIGIT_W-1:0];
    endfunction

endpackage

FILE: hdl/ssr_tick_if.sv
// refresh tick channel: one item per display refresh
interface ssr_tick_if;
    logic                         valid;
    logic                         ready;
    logic [ssr_pkg::MODE_W-1:0]   mode;
    logic [ssr_pkg::ID_W-1:0]     chosen_id;
    logic [ssr_pkg::VALUE_W-1:0]  selected_value;
    logic                         main_switch;
    logic [ssr_pkg::ON_W-1:0]     device_on_bits;

    modport source (output valid, mode, chosen_id, selected_value, main_switch,
                    device_on_bits, input ready);
    modport sink   (input valid, mode, chosen_id, selected_value, main_switch,
                    device_on_bits, output ready);
endinterface

FILE: hdl/ssr_serial_if.sv
// serial bit channel toward the shift register chain
interface ssr_serial_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic latch_after;
    logic last;

    modport source (output valid, data_bit, latch_after, last, input ready);
    modport sink   (input valid, data_bit, latch_after, last, output ready);
endinterface

FILE: hdl/ssr_front.sv
// front end: takes ticks, tracks the digit phase and builds frames
module ssr_front (
    input  logic              clk,
    input  logic              rst_n,
    ssr_tick_if.sink          tick,
    input  logic              q_full,
    output logic              push,
    output ssr_pkg::frame_t   push_frame
);

    logic                             phase_reg;
    logic                             phase_next;
    logic                             accept;
    logic                             new_phase;
    ssr_pkg::mode_t                   mode_v;
    logic [ssr_pkg::ID_W-1:0]         shown;
    logic [ssr_pkg::DIGIT_W-1:0]      tens;
    logic [ssr_pkg::DIGIT_W-1:0]      units;
    logic [7:0]                       sel;
    logic [7:0]                       pattern;
    logic [7:0]                       byte1;
    ssr_pkg::frame_t                  frame;

    assign tick.ready = ~q_full;
    assign accept     = tick.valid & tick.ready;
    assign mode_v     = ssr_pkg::mode_t'(tick.mode);
    assign new_phase  = ~phase_reg;
    assign phase_next = accept ? new_phase : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // value to show, saturated at 99
    always_comb
    begin
        if (mode_v == ssr_pkg::MODE_CHOOSE)
        begin
            shown = (tick.chosen_id > ssr_pkg::DISPLAY_MAX) ? ssr_pkg::DISPLAY_MAX
                                                            : tick.chosen_id;
        end
        else
        begin
            shown = (tick.selected_value > ssr_pkg::VALUE_W'(ssr_pkg::DISPLAY_MAX))
                    ? ssr_pkg::DISPLAY_MAX : tick.selected_value[ssr_pkg::ID_W-1:0];
        end
    end

    assign tens  = ssr_pkg::tens_of(shown);
    assign units = ssr_pkg::units_of(shown, tens);

    always_comb
    begin
        unique case (mode_v) inside
            ssr_pkg::MODE_CHOOSE, ssr_pkg::MODE_CONTROL:
            begin
                sel     = new_phase ? ssr_pkg::SEL_UNITS : ssr_pkg::SEL_TENS;
                pattern = ssr_pkg::seg_pattern(new_phase ? units : tens);
            end
            default:
            begin
                sel     = ssr_pkg::SEL_IDLE;
                pattern = ssr_pkg::seg_pattern('0);
            end
        endcase
    end

    // indicators are active low; ones beyond the chain are dropped
    always_comb
    begin
        frame = '1;
        for (int i = 0; i < ssr_pkg::NUM_INDICATORS; i++)
        begin
            if (i / 8 < ssr_pkg::CHAIN_BYTES)
            begin
                frame[(i / 8) * 8 + 7 - (i % 8)] =
                    ~(tick.main_switch & tick.device_on_bits[i]);
            end
        end
        byte1 = (frame[(ssr_pkg::CHAIN_BYTES - 2) * 8 +: 8] & ssr_pkg::SEL_KEEP_MASK) | sel;
        frame[(ssr_pkg::CHAIN_BYTES - 2) * 8 +: 8] = byte1;
        frame[(ssr_pkg::CHAIN_BYTES - 1) * 8 +: 8] = pattern;
    end

    assign push       = accept && (mode_v != ssr_pkg::MODE_OTHER);
    assign push_frame = frame;

`ifndef NO_ASSERTIONS
    a_other_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode_v == ssr_pkg::MODE_OTHER) |-> !push)
        else $error("mode 3 tick produced a frame");

    a_phase_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (phase_reg != $past(phase_reg)))
        else $error("digit phase did not toggle on tick");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("frame pushed into full queue");
`endif

endmodule

FILE: hdl/ssr_queue.sv
// two-entry frame queue between front and back
module ssr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ssr_pkg::frame_t   push_frame,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output ssr_pkg::frame_t   head_frame
);

    ssr_pkg::frame_t  entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_frame = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

FILE: hdl/ssr_back.sv
// back end: shifts a frame out one bit per transfer
module ssr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ssr_pkg::frame_t   head_frame,
    output logic              pop,
    ssr_serial_if.source      serial
);

    logic                        busy_reg;
    logic                        busy_next;
    ssr_pkg::frame_t             shift_reg;
    ssr_pkg::frame_t             shift_next;
    logic [ssr_pkg::CNT_W-1:0]   cnt_reg;
    logic [ssr_pkg::CNT_W-1:0]   cnt_next;
    logic                        xfer;
    logic                        done;
    logic                        load;

    assign xfer = serial.valid & serial.ready;
    assign done = xfer && (cnt_reg == ssr_pkg::LAST_BIT);
    assign load = head_valid && (!busy_reg || done);
    assign pop  = load;

    always_comb
    begin
        busy_next  = busy_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            shift_next = head_frame;
            cnt_next   = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (xfer)
        begin
            shift_next = {shift_reg[ssr_pkg::FRAME_BITS-2:0], 1'b1};
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign serial.valid       = busy_reg;
    assign serial.data_bit    = shift_reg[ssr_pkg::FRAME_BITS-1];
    assign serial.latch_after = (cnt_reg[2:0] == 3'b111);
    assign serial.last        = (cnt_reg == ssr_pkg::LAST_BIT);

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= ssr_pkg::LAST_BIT))
        else $error("bit counter past end of frame");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && !head_valid |=> !busy_reg)
        else $error("still busy after final bit with no frame queued");

    a_chain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && head_valid |=> busy_reg && (cnt_reg == '0))
        else $error("queued frame not started after final bit");
`endif

endmodule

FILE: hdl/seven_segment_led_chain_refresh.sv
// top level of the seven-segment refresh for a chain of shift registers
//
// tick channel: one transfer per display refresh, carrying mode, chosen_id,
//   selected_value, main_switch and device_on_bits
// serial channel: one transfer per serial bit, data_bit plus latch_after
//   (storage latch follows, every eighth bit) and last (final bit of frame)
// a frame is ssr_pkg::CHAIN_BYTES bytes, byte 0 first, msb first; byte 0 is the
//   segment pattern, byte 1 bits 1:0 the digit select, the rest indicators
// mode 3 ticks are taken and toggle the digit phase but send no frame
// a tick's frame is registered into a queue entry, then loaded into the shifter,
//   whose top bit is then offered as the first bit of the frame
// throughput: one bit per cycle while the receiver is ready, set by the serial
//   shifter; frames follow each other with no gap when the next one is queued
// the front builds a whole frame in the tick cycle and a two-entry queue holds
//   frames, so ticks are taken while the shifter still streams a frame
// reset clears the digit phase (first tick shows units), empties the queue and
//   idles the shifter
// when the receiver stalls the shifter holds its bit; ticks keep flowing until
//   the queue is full, then tick.ready drops
module seven_segment_led_chain_refresh (
    input  logic          clk,
    input  logic          rst_n,
    ssr_tick_if.sink      tick,
    ssr_serial_if.source  serial
);

    // front to queue
    logic             push;
    ssr_pkg::frame_t  push_frame;
    logic             q_full;

    // queue to back
    logic             pop;
    logic             head_valid;
    ssr_pkg::frame_t  head_frame;

    ssr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .q_full     (q_full),
        .push       (push),
        .push_frame (push_frame)
    );

    ssr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_frame (head_frame)
    );

    ssr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_frame (head_frame),
        .pop        (pop),
        .serial     (serial)
    );

endmodule
